// ===== rtl/bnf_pkg.sv =====
// Shared types and constants for the binary image neighborhood fetch unit.
// Used by every module in rtl/; has no dependencies of its own.
package bnf_pkg;

    // Fixed field widths of the request and result beats
    localparam int COORD_W    = 5;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;
    localparam int WIN_BITS   = 9;
    localparam int STEP_W     = 4;
    localparam int CMP_W      = 10;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Request op codes as they arrive on the stream
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ_PIX = 2'd1;
    localparam logic [1:0] OP_READ_WIN = 2'd2;

    // Result kind codes
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    // Window steps: center step for a single read, last step of a window read
    localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CENTER = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_READ_PIX = 2'd1,
        CMD_READ_WIN = 2'd2
    } cmd_op_t;

    typedef struct packed {
        logic               requester;
        cmd_op_t            op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               write_bit;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2
    } back_state_t;

    typedef struct packed {
        logic scanning;
        logic draining;
    } back_status_t;

    // Row and column offsets (plus one) of each window step, row by row
    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } step_off_t;

    function automatic step_off_t step_offsets(input logic [STEP_W-1:0] step);
        step_off_t off;
        begin
            unique case (step)
                4'd0:    off = '{dr: 2'd0, dc: 2'd0};
                4'd1:    off = '{dr: 2'd0, dc: 2'd1};
                4'd2:    off = '{dr: 2'd0, dc: 2'd2};
                4'd3:    off = '{dr: 2'd1, dc: 2'd0};
                4'd4:    off = '{dr: 2'd1, dc: 2'd1};
                4'd5:    off = '{dr: 2'd1, dc: 2'd2};
                4'd6:    off = '{dr: 2'd2, dc: 2'd0};
                4'd7:    off = '{dr: 2'd2, dc: 2'd1};
                4'd8:    off = '{dr: 2'd2, dc: 2'd2};
                default: off = '{dr: 2'd1, dc: 2'd1};
            endcase
            return off;
        end
    endfunction

endpackage

// ===== rtl/bnf_front.sv =====
// Request front end: accepts request beats, decodes and filters them into commands.
// Depends on bnf_pkg.
module bnf_front #(
    parameter int IMAGE_SIDE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bnf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [bnf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output bnf_pkg::cmd_t                  push_cmd
);

    localparam logic [bnf_pkg::CMP_W-1:0] SideCmp = bnf_pkg::CMP_W'(IMAGE_SIDE);

    logic                         fr_valid_reg;
    logic                         fr_valid_next;
    bnf_pkg::cmd_t                fr_cmd_reg;
    bnf_pkg::cmd_t                fr_cmd_next;
    logic                         accept;
    logic                         push;
    logic                         keep;
    logic                         in_image;
    logic [1:0]                   op_code;
    logic [bnf_pkg::COORD_W-1:0]  in_row;
    logic [bnf_pkg::COORD_W-1:0]  in_col;

    assign op_code  = s_axis_tuser[2:1];
    assign in_row   = s_axis_tdata[4:0];
    assign in_col   = s_axis_tdata[9:5];
    assign in_image = (bnf_pkg::CMP_W'(in_row) < SideCmp) &&
                      (bnf_pkg::CMP_W'(in_col) < SideCmp);

    assign push          = fr_valid_reg && push_ready;
    assign s_axis_tready = !fr_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = fr_valid_reg;
    assign push_cmd      = fr_cmd_reg;

    // Decode the beat; drop unused op codes and writes outside the image
    always_comb
    begin
        fr_cmd_next           = fr_cmd_reg;
        keep                  = 1'b0;
        if (accept)
        begin
            fr_cmd_next.requester = s_axis_tuser[0];
            fr_cmd_next.row       = in_row;
            fr_cmd_next.col       = in_col;
            fr_cmd_next.write_bit = s_axis_tdata[10];
            unique case (op_code)
                bnf_pkg::OP_WRITE:
                begin
                    fr_cmd_next.op = bnf_pkg::CMD_WRITE;
                    keep           = in_image;
                end
                bnf_pkg::OP_READ_PIX:
                begin
                    fr_cmd_next.op = bnf_pkg::CMD_READ_PIX;
                    keep           = 1'b1;
                end
                bnf_pkg::OP_READ_WIN:
                begin
                    fr_cmd_next.op = bnf_pkg::CMD_READ_WIN;
                    keep           = 1'b1;
                end
                default:
                begin
                    fr_cmd_next.op = bnf_pkg::CMD_WRITE;
                    keep           = 1'b0;
                end
            endcase
        end
        fr_valid_next = (fr_valid_reg && !push) || (accept && keep);
    end

    // Hold the decoded command until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_cmd_reg <= fr_cmd_next;
    end

endmodule

// ===== rtl/bnf_queue.sv =====
// Short command queue between the front end and the memory sequencer.
// Depends on bnf_pkg.
module bnf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bnf_pkg::cmd_t push_cmd,
    output logic          head_valid,
    input  logic          pop,
    output bnf_pkg::cmd_t head_cmd
);

    bnf_pkg::cmd_t               entry_reg [bnf_pkg::QUEUE_DEPTH];
    logic [bnf_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [bnf_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [bnf_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [bnf_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [bnf_pkg::QCNT_W-1:0]  count_reg;
    logic [bnf_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != bnf_pkg::QCNT_W'(bnf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/bnf_back.sv =====
// Memory sequencer: owns the single-port image memory, runs writes and
// one-pixel or 3x3 window reads, and holds the result beat. Depends on bnf_pkg.
module bnf_back #(
    parameter int IMAGE_SIDE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  bnf_pkg::cmd_t                  head_cmd,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bnf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [bnf_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output bnf_pkg::back_status_t          status
);

    localparam int Depth = IMAGE_SIDE * IMAGE_SIDE;
    localparam int AddrW = $clog2(Depth);
    localparam logic [bnf_pkg::CMP_W-1:0] SideCmp = bnf_pkg::CMP_W'(IMAGE_SIDE);
    localparam int ExtW = bnf_pkg::COORD_W + 1;

    logic                          mem [Depth];
    logic                          mem_q_reg;
    logic                          mem_we;
    logic                          mem_re;
    logic [AddrW-1:0]              mem_addr;

    bnf_pkg::back_state_t          state_reg;
    bnf_pkg::back_state_t          state_next;
    logic                          who_reg;
    logic                          who_next;
    logic                          kind_reg;
    logic                          kind_next;
    logic [bnf_pkg::COORD_W-1:0]   row_reg;
    logic [bnf_pkg::COORD_W-1:0]   row_next;
    logic [bnf_pkg::COORD_W-1:0]   col_reg;
    logic [bnf_pkg::COORD_W-1:0]   col_next;
    logic [bnf_pkg::STEP_W-1:0]    step_reg;
    logic [bnf_pkg::STEP_W-1:0]    step_next;
    logic [bnf_pkg::STEP_W-1:0]    stop_reg;
    logic [bnf_pkg::STEP_W-1:0]    stop_next;
    logic [bnf_pkg::WIN_BITS-1:0]  win_reg;
    logic [bnf_pkg::WIN_BITS-1:0]  win_next;
    logic [bnf_pkg::WIN_BITS-1:0]  win_cur;
    logic                          rd_pend_reg;
    logic                          rd_pend_next;
    logic [bnf_pkg::STEP_W-1:0]    rd_idx_reg;
    logic [bnf_pkg::STEP_W-1:0]    rd_idx_next;
    logic                          rd_in_reg;
    logic                          rd_in_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_who_reg;
    logic                          out_who_next;
    logic                          out_kind_reg;
    logic                          out_kind_next;
    logic                          out_pix_reg;
    logic                          out_pix_next;
    logic [bnf_pkg::WIN_BITS-1:0]  out_win_reg;
    logic [bnf_pkg::WIN_BITS-1:0]  out_win_next;
    logic                          out_free;

    bnf_pkg::step_off_t            off;
    logic [ExtW-1:0]               nr_ext;
    logic [ExtW-1:0]               nc_ext;
    logic [ExtW-1:0]               nr_idx;
    logic [ExtW-1:0]               nc_idx;
    logic                          n_inside;
    logic [AddrW-1:0]              scan_addr;
    logic [AddrW-1:0]              wr_addr;

    // Neighbor coordinates of the current step, offset by one so they stay unsigned
    always_comb
    begin
        off      = bnf_pkg::step_offsets(step_reg);
        nr_ext   = ExtW'(row_reg) + ExtW'(off.dr);
        nc_ext   = ExtW'(col_reg) + ExtW'(off.dc);
        nr_idx   = nr_ext - 1'b1;
        nc_idx   = nc_ext - 1'b1;
        n_inside = (nr_ext != '0) && (nc_ext != '0) &&
                   (bnf_pkg::CMP_W'(nr_ext) <= SideCmp) &&
                   (bnf_pkg::CMP_W'(nc_ext) <= SideCmp);
        scan_addr = AddrW'(32'(nr_idx) * 32'(IMAGE_SIDE) + 32'(nc_idx));
        wr_addr   = AddrW'(32'(head_cmd.row) * 32'(IMAGE_SIDE) + 32'(head_cmd.col));
    end

    // Merge the read returning this cycle into the window
    always_comb
    begin
        win_cur = win_reg;
        for (int i = 0; i < bnf_pkg::WIN_BITS; i++)
        begin
            if (rd_pend_reg && (rd_idx_reg == bnf_pkg::STEP_W'(i)))
            begin
                win_cur[i] = rd_in_reg && mem_q_reg;
            end
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // Sequencer: next state, memory port and result load
    always_comb
    begin
        state_next     = state_reg;
        who_next       = who_reg;
        kind_next      = kind_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        step_next      = step_reg;
        stop_next      = stop_reg;
        win_next       = win_cur;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_in_next     = rd_in_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = scan_addr;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_who_next   = out_who_reg;
        out_kind_next  = out_kind_reg;
        out_pix_next   = out_pix_reg;
        out_win_next   = out_win_reg;

        unique case (state_reg)
            bnf_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    who_next  = head_cmd.requester;
                    row_next  = head_cmd.row;
                    col_next  = head_cmd.col;
                    win_next  = '0;
                    unique case (head_cmd.op)
                        bnf_pkg::CMD_WRITE:
                        begin
                            mem_we   = 1'b1;
                            mem_addr = wr_addr;
                        end
                        bnf_pkg::CMD_READ_PIX:
                        begin
                            kind_next  = bnf_pkg::KIND_PIXEL;
                            step_next  = bnf_pkg::STEP_CENTER;
                            stop_next  = bnf_pkg::STEP_CENTER;
                            state_next = bnf_pkg::ST_SCAN;
                        end
                        bnf_pkg::CMD_READ_WIN:
                        begin
                            kind_next  = bnf_pkg::KIND_WINDOW;
                            step_next  = bnf_pkg::STEP_FIRST;
                            stop_next  = bnf_pkg::STEP_LAST;
                            state_next = bnf_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = bnf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bnf_pkg::ST_SCAN:
            begin
                // Issue one neighbor read per cycle; outside neighbors read as zero
                mem_re       = n_inside;
                rd_pend_next = 1'b1;
                rd_idx_next  = step_reg;
                rd_in_next   = n_inside;
                step_next    = step_reg + 1'b1;
                if (step_reg == stop_reg)
                begin
                    state_next = bnf_pkg::ST_DRAIN;
                end
            end
            bnf_pkg::ST_DRAIN:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_who_next   = who_reg;
                    out_kind_next  = kind_reg;
                    if (kind_reg == bnf_pkg::KIND_WINDOW)
                    begin
                        out_pix_next = 1'b0;
                        out_win_next = win_cur;
                    end
                    else
                    begin
                        out_pix_next = win_cur[bnf_pkg::STEP_CENTER];
                        out_win_next = '0;
                    end
                    state_next = bnf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bnf_pkg::ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        who_reg      <= who_next;
        kind_reg     <= kind_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        step_reg     <= step_next;
        stop_reg     <= stop_next;
        win_reg      <= win_next;
        rd_idx_reg   <= rd_idx_next;
        rd_in_reg    <= rd_in_next;
        out_who_reg  <= out_who_next;
        out_kind_reg <= out_kind_next;
        out_pix_reg  <= out_pix_next;
        out_win_reg  <= out_win_next;
    end

    // Single-port image memory with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= head_cmd.write_bit;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser    = {out_kind_reg, out_who_reg};
    assign m_axis_tdata    = {{(bnf_pkg::M_TDATA_W - bnf_pkg::WIN_BITS - 1){1'b0}},
                              out_win_reg, out_pix_reg};
    assign status.scanning = (state_reg == bnf_pkg::ST_SCAN);
    assign status.draining = (state_reg == bnf_pkg::ST_DRAIN);

endmodule

// ===== rtl/binary_image_neighborhood_fetch_unit.sv =====
// Binary image neighborhood fetch unit: single-bit image memory with pixel and 3x3 reads.
// Throughput is set by the single-port image memory, one read per cycle; a read holds
// the sequencer until its result is loaded, and a write does not leave the idle state.
// Reset (rst_n, asynchronous, active low) empties the queue and result register;
// image contents are undefined until written.
module binary_image_neighborhood_fetch_unit #(
    parameter int IMAGE_SIDE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // row[4:0], col[9:5], write_bit[10], zero[15:11]
    input  logic [bnf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // requester[0], op[2:1]
    input  logic [bnf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_bit[0], window[9:1], zero[15:10]
    output logic [bnf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // requester_echo[0], kind[1]
    output logic [bnf_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    logic                   fr_push_valid;
    logic                   q_push_ready;
    bnf_pkg::cmd_t          fr_push_cmd;
    logic                   q_head_valid;
    bnf_pkg::cmd_t          q_head_cmd;
    logic                   q_pop;
    bnf_pkg::back_status_t  bk_status;

    bnf_front #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (fr_push_valid),
        .push_ready    (q_push_ready),
        .push_cmd      (fr_push_cmd)
    );

    bnf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (fr_push_cmd),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head_cmd   (q_head_cmd)
    );

    bnf_back #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head_cmd      (q_head_cmd),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .status        (bk_status)
    );

    // A new result only appears at the end of a read sequence
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(bk_status.draining))
        else $error("result raised without a finished read sequence");

    // The sequencer only takes a command that the queue holds
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");

    // The front stalls only while it holds a command the queue refuses
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (fr_push_valid && !q_push_ready))
        else $error("request stalled without a blocked command");

    // A scan always continues or finishes into the drain step
    a_scan_progress: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.scanning |=> (bk_status.scanning || bk_status.draining))
        else $error("read sequence abandoned");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the binary image neighborhood fetch unit.
// Depends on rtl/bnf_pkg.sv and rtl/binary_image_neighborhood_fetch_unit.sv;
// predicts every result beat from its own copy of the image and checks it in order.
`timescale 1ns / 100ps

module testbench;

    localparam int          SIDE        = 32;
    localparam int          STORE_DEPTH = SIDE * SIDE;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 105;
    localparam int          BAND_N      = 12;
    localparam int          CENTER_N    = 8;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic                        requester;
        logic [1:0]                  op;
        logic [bnf_pkg::COORD_W-1:0] row;
        logic [bnf_pkg::COORD_W-1:0] col;
        logic                        write_bit;
    } request_t;

    typedef struct packed {
        logic                         requester_echo;
        logic                         kind;
        logic                         pixel_bit;
        logic [bnf_pkg::WIN_BITS-1:0] window;
    } fetch_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [bnf_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic [bnf_pkg::S_TUSER_W-1:0]  s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [bnf_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic [bnf_pkg::M_TUSER_W-1:0]  m_axis_tuser;

    // Predicted image contents and results still owed by the block
    logic          image_mem [0:STORE_DEPTH-1];
    fetch_result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int writes_sent    = 0;
    int pixel_reads    = 0;
    int window_reads   = 0;
    int ignored_sent   = 0;
    int results_seen   = 0;

    binary_image_neighborhood_fetch_unit #(
        .IMAGE_SIDE(SIDE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Read one pixel of the predicted image, zero outside the borders
    function automatic logic image_pixel(input int r, input int c);
        if (r < 0 || c < 0 || r >= SIDE || c >= SIDE)
            return 1'b0;
        return image_mem[r * SIDE + c];
    endfunction

    // Update the image copy and queue the result the request causes
    function automatic void predict_request(input request_t req);
        fetch_result_t res;
        int            r;
        int            c;
        int            k;
        r   = int'(req.row);
        c   = int'(req.col);
        res = '0;
        res.requester_echo = req.requester;
        case (req.op)
            bnf_pkg::OP_WRITE:
            begin
                if (r < SIDE && c < SIDE)
                    image_mem[r * SIDE + c] = req.write_bit;
                writes_sent++;
            end
            bnf_pkg::OP_READ_PIX:
            begin
                res.kind      = bnf_pkg::KIND_PIXEL;
                res.pixel_bit = image_pixel(r, c);
                pending_results.push_back(res);
                pixel_reads++;
            end
            bnf_pkg::OP_READ_WIN:
            begin
                res.kind = bnf_pkg::KIND_WINDOW;
                k = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        res.window[k] = image_pixel(r + dr, c + dc);
                        k++;
                    end
                pending_results.push_back(res);
                window_reads++;
            end
            default:
                ignored_sent++;
        endcase
    endfunction

    function automatic request_t make_req(input logic who, input logic [1:0] op,
                                          input int r, input int c, input logic wbit);
        request_t req;
        req.requester = who;
        req.op        = op;
        req.row       = r[bnf_pkg::COORD_W-1:0];
        req.col       = c[bnf_pkg::COORD_W-1:0];
        req.write_bit = wbit;
        return req;
    endfunction

    // Drive one request beat, with random idle cycles ahead of it
    task automatic send_request(input request_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, req.write_bit, req.col, req.row};
        s_axis_tuser  <= {req.op, req.requester};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(req);
    endtask

    // Drop valid and hold until every owed result has been checked
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Check each result beat against the oldest prediction, randomize tready
    always @(posedge clk)
    begin
        fetch_result_t got;
        fetch_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.requester_echo = m_axis_tuser[0];
            got.kind           = m_axis_tuser[1];
            got.pixel_bit      = m_axis_tdata[0];
            got.window         = m_axis_tdata[9:1];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", int'(got), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.requester_echo !== want.requester_echo)
                    report_mismatch("requester_echo", int'(got.requester_echo),
                                    int'(want.requester_echo));
                if (got.kind !== want.kind)
                    report_mismatch("kind", int'(got.kind), int'(want.kind));
                if (got.pixel_bit !== want.pixel_bit)
                    report_mismatch("pixel_bit", int'(got.pixel_bit), int'(want.pixel_bit));
                if (got.window !== want.window)
                    report_mismatch("window", int'(got.window), int'(want.window));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Write every pixel a read can reach: the border bands and a middle band
    task automatic test_fill_image();
        int band [BAND_N] = '{0, 1, 2, 3, SIDE / 2 - 2, SIDE / 2 - 1, SIDE / 2,
                              SIDE / 2 + 1, SIDE - 4, SIDE - 3, SIDE - 2, SIDE - 1};
        for (int i = 0; i < BAND_N; i++)
            for (int j = 0; j < BAND_N; j++)
                send_request(make_req(1'($urandom_range(1)), bnf_pkg::OP_WRITE,
                                      band[i], band[j], 1'($urandom_range(1))));
        wait_drained();
    endtask

    // Corners, edges, both requesters, read after write, ignored op
    task automatic test_directed();
        send_request(make_req(1'b0, bnf_pkg::OP_WRITE,     0,  0, 1'b1));
        send_request(make_req(1'b1, bnf_pkg::OP_WRITE,    31, 31, 1'b1));
        send_request(make_req(1'b0, bnf_pkg::OP_WRITE,     0, 31, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_WRITE,    31,  0, 1'b1));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_WIN,  0,  0, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN,  0, 31, 1'b1));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_WIN, 31,  0, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN, 31, 31, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN,  0, 15, 1'b0));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_WIN, 31, 15, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN, 15,  0, 1'b0));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_WIN, 15, 31, 1'b0));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_PIX,  0,  0, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_PIX, 31, 31, 1'b1));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_PIX,  0, 31, 1'b0));
        // Read straight after a write to the same pixel
        send_request(make_req(1'b0, bnf_pkg::OP_WRITE,    15, 15, 1'b1));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN, 15, 15, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_WRITE,    15, 15, 1'b0));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_PIX, 15, 15, 1'b0));
        // Unused op code must leave the image alone and answer nothing
        send_request(make_req(1'b0, bnf_pkg::OP_WRITE,    16, 16, 1'b0));
        send_request(make_req(1'b1, OP_UNUSED,            16, 16, 1'b1));
        send_request(make_req(1'b0, bnf_pkg::OP_READ_PIX, 16, 16, 1'b0));
        send_request(make_req(1'b1, bnf_pkg::OP_READ_WIN, 16, 16, 1'b0));
        wait_drained();
    endtask

    // Pick a target whose whole window lies in the written bands
    function automatic int pick_coord();
        int centers [CENTER_N] = '{0, 1, 2, SIDE / 2 - 1, SIDE / 2,
                                   SIDE - 3, SIDE - 2, SIDE - 1};
        return centers[$urandom_range(CENTER_N - 1)];
    endfunction

    // Random mix of requests, with write-then-window bursts around one pixel
    task automatic test_random_phase(input string label, input int send_pct,
                                     input int recv_pct, input int count);
        int         sel;
        int         r;
        int         c;
        logic [1:0] op;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        $display("Phase %s: sender idle %0d%%, receiver stall %0d%%", label, send_pct, recv_pct);
        for (int n = 0; n < count; n++)
        begin
            r   = pick_coord();
            c   = pick_coord();
            sel = $urandom_range(99);
            if (sel < 12)
            begin
                // Burst: rewrite a few neighbors, then fetch the window
                repeat ($urandom_range(3, 1))
                    send_request(make_req(1'($urandom_range(1)), bnf_pkg::OP_WRITE,
                                          (r + $urandom_range(2) + SIDE - 1) % SIDE,
                                          (c + $urandom_range(2) + SIDE - 1) % SIDE,
                                          1'($urandom_range(1))));
                op = bnf_pkg::OP_READ_WIN;
            end
            else if (sel < 35)
                op = bnf_pkg::OP_WRITE;
            else if (sel < 60)
                op = bnf_pkg::OP_READ_PIX;
            else if (sel < 95)
                op = bnf_pkg::OP_READ_WIN;
            else
                op = OP_UNUSED;
            send_request(make_req(1'($urandom_range(1)), op, r, c, 1'($urandom_range(1))));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        for (int a = 0; a < STORE_DEPTH; a++)
            image_mem[a] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_fill_image();
        test_directed();
        test_random_phase("steady",        0,  0, PHASE_ITEMS);
        test_random_phase("sender idle",  88,  0, PHASE_ITEMS);
        test_random_phase("receiver stall", 0, 88, PHASE_ITEMS);
        test_random_phase("both idle",    27, 27, PHASE_ITEMS);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("Covered %0d writes, %0d pixel reads, %0d window reads, %0d ignored ops",
                 writes_sent, pixel_reads, window_reads, ignored_sent);
        $display("Checked %0d result beats in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
